// File: rtl/core/ppt_pkg.sv
// ---------------------------------------------------------------------------
// ppt_pkg
// Shared types and constants of the perspective point transform.
// ---------------------------------------------------------------------------
`default_nettype none
package ppt_pkg;
	localparam int COEF_FRAC_BITS = 16;
	localparam int COORD_WIDTH    = 32;
	localparam int W_SHIFT        = 6 + COEF_FRAC_BITS;
	localparam logic [63:0] W_FLOOR = 64'(((64'd1 << W_SHIFT) + 64'd10) / 64'd20);

	localparam int SUM_W  = 66;
	localparam int NUM_W  = SUM_W + 6;
	localparam int QBITS  = 33;
	localparam int DIV_LAT = QBITS + 2;

	typedef enum logic [2:0] {
		REG_X_ROW     = 3'd0,
		REG_Y_ROW     = 3'd1,
		REG_W_ROW     = 3'd2,
		REG_TRANSLATE = 3'd3,
		REG_W_OFFSET  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
	} in_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic               w_clamped;
	} out_t;
endpackage
`default_nettype wire

// File: rtl/core/ppt_div.sv
// ---------------------------------------------------------------------------
// ppt_div
// Pipelined restoring divider: trunc(64*mag/den), one quotient bit a stage,
// sign applied and saturated at the end.
// ---------------------------------------------------------------------------
`default_nettype none
module ppt_div (
	input  wire logic                       clk,
	input  wire logic [ppt_pkg::SUM_W-1:0]  mag,
	input  wire logic                       neg,
	input  wire logic [63:0]                den,
	output logic signed [31:0]              quot
);
	import ppt_pkg::*;

	logic [NUM_W-1:0] num;
	logic [63:0]      rem_s  [0:QBITS];
	logic [QBITS-1:0] q_s    [0:QBITS];
	logic [QBITS-1:0] nlo_s  [0:QBITS];
	logic [63:0]      den_s  [0:QBITS];
	logic             neg_s  [0:QBITS];
	logic             ovf_s  [0:QBITS];

	logic [QBITS:0]   lim;
	logic [QBITS:0]   qext;
	logic [QBITS:0]   val;
	logic [QBITS:0]   sres;

	assign num = {mag, 6'b0};

	always_ff @(posedge clk) begin
		rem_s[0] <= 64'(num[NUM_W-1:QBITS]);
		nlo_s[0] <= num[QBITS-1:0];
		q_s[0]   <= '0;
		den_s[0] <= den;
		neg_s[0] <= neg;
		ovf_s[0] <= 64'(num[NUM_W-1:QBITS]) >= den;
	end

	for (genvar k = 0; k < QBITS; k++) begin : g_stage
		logic [64:0] r;
		logic        ge;
		assign r  = {rem_s[k], nlo_s[k][QBITS-1]};
		assign ge = r >= {1'b0, den_s[k]};
		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? 64'(r - {1'b0, den_s[k]}) : r[63:0];
			q_s[k+1]   <= {q_s[k][QBITS-2:0], ge};
			nlo_s[k+1] <= {nlo_s[k][QBITS-2:0], 1'b0};
			den_s[k+1] <= den_s[k];
			neg_s[k+1] <= neg_s[k];
			ovf_s[k+1] <= ovf_s[k];
		end
	end

	always_comb begin
		lim  = ((QBITS+1)'(1) << (COORD_WIDTH - 1)) - (QBITS+1)'(1);
		if (neg_s[QBITS])
			lim = lim + (QBITS+1)'(1);
		qext = {1'b0, q_s[QBITS]};
		val  = (ovf_s[QBITS] || qext > lim) ? lim : qext;
		sres = neg_s[QBITS] ? (~val + (QBITS+1)'(1)) : val;
	end

	always_ff @(posedge clk) begin
		quot <= sres[31:0];
	end
endmodule
`default_nettype wire

// File: rtl/core/perspective_point_transform.sv
// ---------------------------------------------------------------------------
// perspective_point_transform
// Projects a 26.6 point through the x, y and w rows of a 4x4 matrix.
// ---------------------------------------------------------------------------
// Usage:
//  - Input: a transaction is taken at each clock edge with start high and
//    busy low. busy never rises, so a point may enter every cycle.
//  - Output: each result is shown for one cycle with result_valid high,
//    in input order.
//  - Throughput: one point per cycle. The path runs through multiply, sum
//    and sign/floor stages, then the bit-per-stage divider.
//  - Config: cfg_valid/cfg_ready write channel, cfg_ready is always high.
//    Write only while the pipeline is empty. Unknown indexes are ignored.
//  - Reset: clears all valid bits and loads the identity transform.
//  - The receiver cannot stall; results are never held.
// ---------------------------------------------------------------------------
`default_nettype none
module perspective_point_transform (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire ppt_pkg::in_t  point,
	output logic               result_valid,
	output ppt_pkg::out_t      result,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [2:0]    cfg_index,
	input  wire logic [63:0]   cfg_data
);
	import ppt_pkg::*;

	logic [63:0] x_row_q, y_row_q, w_row_q, trans_q;
	logic [31:0] w_off_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_row_q <= 64'd1 << (32 + COEF_FRAC_BITS);
			y_row_q <= 64'd1 << COEF_FRAC_BITS;
			w_row_q <= '0;
			trans_q <= '0;
			w_off_q <= 32'd1 << COEF_FRAC_BITS;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_X_ROW:     x_row_q <= cfg_data;
				REG_Y_ROW:     y_row_q <= cfg_data;
				REG_W_ROW:     w_row_q <= cfg_data;
				REG_TRANSLATE: trans_q <= cfg_data;
				REG_W_OFFSET:  w_off_q <= cfg_data[31:0];
				default:       ;
			endcase
		end
	end

	// stage 1: products
	logic                accept;
	logic                valid_s1, valid_s2, valid_s3;
	logic signed [63:0]  pxa_s1, pya_s1, pxb_s1, pyb_s1, pxc_s1, pyc_s1;
	logic signed [37:0]  kx_s1, ky_s1, kw_s1;

	assign accept = start && !busy;

	always_ff @(posedge clk) begin
		pxa_s1 <= point.point_x * $signed(x_row_q[63:32]);
		pya_s1 <= point.point_y * $signed(x_row_q[31:0]);
		pxb_s1 <= point.point_x * $signed(y_row_q[63:32]);
		pyb_s1 <= point.point_y * $signed(y_row_q[31:0]);
		pxc_s1 <= point.point_x * $signed(w_row_q[63:32]);
		pyc_s1 <= point.point_y * $signed(w_row_q[31:0]);
		kx_s1  <= {$signed(trans_q[63:32]), 6'b0};
		ky_s1  <= {$signed(trans_q[31:0]), 6'b0};
		kw_s1  <= {$signed(w_off_q), 6'b0};
	end

	// stage 2: row sums
	logic signed [SUM_W-1:0] tx_s2, ty_s2, tw_s2;

	always_ff @(posedge clk) begin
		tx_s2 <= SUM_W'(pxa_s1) + SUM_W'(pya_s1) + SUM_W'(kx_s1);
		ty_s2 <= SUM_W'(pxb_s1) + SUM_W'(pyb_s1) + SUM_W'(ky_s1);
		tw_s2 <= SUM_W'(pxc_s1) + SUM_W'(pyc_s1) + SUM_W'(kw_s1);
	end

	// stage 3: sign fix, floor, magnitudes
	logic [SUM_W-1:0] aw, ax, ay;
	logic [63:0]      den_s3;
	logic             clamp_s3, negx_s3, negy_s3;
	logic [SUM_W-1:0] magx_s3, magy_s3;

	always_comb begin
		aw = tw_s2[SUM_W-1] ? SUM_W'(-tw_s2) : tw_s2;
		ax = tx_s2[SUM_W-1] ? SUM_W'(-tx_s2) : tx_s2;
		ay = ty_s2[SUM_W-1] ? SUM_W'(-ty_s2) : ty_s2;
	end

	always_ff @(posedge clk) begin
		clamp_s3 <= aw[63:0] < W_FLOOR;
		den_s3   <= (aw[63:0] < W_FLOOR) ? W_FLOOR : aw[63:0];
		magx_s3  <= ax;
		magy_s3  <= ay;
		negx_s3  <= tx_s2[SUM_W-1] ^ tw_s2[SUM_W-1];
		negy_s3  <= ty_s2[SUM_W-1] ^ tw_s2[SUM_W-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// divider stages
	logic signed [31:0] qx, qy;

	ppt_div u_div_x (
		.clk  (clk),
		.mag  (magx_s3),
		.neg  (negx_s3),
		.den  (den_s3),
		.quot (qx)
	);

	ppt_div u_div_y (
		.clk  (clk),
		.mag  (magy_s3),
		.neg  (negy_s3),
		.den  (den_s3),
		.quot (qy)
	);

	logic [DIV_LAT-1:0] dvalid_q;
	logic [DIV_LAT-1:0] dclamp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvalid_q <= '0;
		end else begin
			dvalid_q <= {dvalid_q[DIV_LAT-2:0], valid_s3};
		end
	end

	always_ff @(posedge clk) begin
		dclamp_q <= {dclamp_q[DIV_LAT-2:0], clamp_s3};
	end

	assign result_valid     = dvalid_q[DIV_LAT-1];
	assign result.out_x     = qx;
	assign result.out_y     = qy;
	assign result.w_clamped = dclamp_q[DIV_LAT-1];

	a_den_floor: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> den_s3 >= W_FLOOR)
		else $error("denominator below floor");

	a_clamp_den: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && clamp_s3 |-> den_s3 == W_FLOOR)
		else $error("clamped transaction without floor denominator");

	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |=> valid_s3 && dvalid_q[0] == $past(valid_s3))
		else $error("valid bit lost in pipeline");
endmodule
`default_nettype wire
